/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL that carries concurrent checks.
// Depends on nothing; included by the top level of the evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off during reset.
`define BPE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define BPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bpe_pkg.sv */
// Package of the Bezier point evaluator: sizes, item types, codes, cell control.
// Depends on nothing; used by bpe_cell and bezier_point_evaluator.
`default_nettype none

package bpe_pkg;

    localparam int MAX_POINTS  = 8;
    localparam int T_FRAC_BITS = 16;

    localparam int COORD_W   = 24;
    localparam int T_W       = T_FRAC_BITS + 1;
    localparam int PIDX_W    = 3;
    localparam int CNT_W     = 4;
    localparam int CNT_EFF_W = $clog2(MAX_POINTS + 1);
    localparam int RND_W     = $clog2(MAX_POINTS);
    localparam int PROD_W    = COORD_W + 1 + T_W + 1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);
    localparam logic [T_W-1:0]   T_ONE       = T_W'(1) << T_FRAC_BITS;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [PIDX_W-1:0]         point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [T_W-1:0]            t_value;
    } bpe_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] curve_x;
        logic signed [COORD_W-1:0] curve_y;
    } bpe_out_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic copy;   // working point <= control point
        logic mul;    // product <= (neighbor - own) * t
        logic add;    // working point <= own + product >>> T_FRAC_BITS
    } bpe_cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/bezier_point_evaluator.sv */
// Top level of the Bezier point evaluator: sequencer, config register, output stage.
// Depends on bpe_pkg, bpe_cell and assert_macros.svh.
//
// Usage:
//   in channel (in_valid/in_ready/in_item): a load item (kind 0) writes control
//   point point_index and gives no result; an evaluate item (kind 1) gives one
//   curve point at t_value (values above 1.0 clamp to 1.0).
//   out channel (out_valid/out_ready/out_item): one item per evaluate.
//   cfg_wr_en/cfg_wr_data: point_count, written in one cycle while idle; 0 acts
//   as 1, values above MAX_POINTS act as MAX_POINTS.
// Sequence, with n the effective point count:
//   loads may follow back to back while the sequencer is idle.
//   an evaluate runs n-1 rounds through the cell chain; each round is a
//   per-cell multiply step followed by an add step. After the last round the
//   output state loads the result into the output register and returns to
//   idle; no new item is taken before then.
// Reset clears the sequencer and the output valid and sets point_count to 4;
// control points are undefined until loaded.
// A stalled receiver holds the result in the output register; loads are still
// taken meanwhile, and a finished evaluate waits in the output state for the slot.
`default_nettype none

module bezier_point_evaluator
    import bpe_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire bpe_in_t    in_item,
    output logic            out_valid,
    input  wire             out_ready,
    output bpe_out_t        out_item,
    input  wire             cfg_wr_en,
    input  wire [CNT_W-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     point_count_reg, point_count_next;
    logic [RND_W-1:0]     rounds_reg, rounds_next;
    logic [T_W-1:0]       t_reg, t_next;
    logic                 out_valid_reg, out_valid_next;
    bpe_out_t             out_item_reg, out_item_next;

    logic                 in_accept;
    logic                 eval_start;
    logic [CNT_EFF_W-1:0] count_eff;
    bpe_cell_ctl_t        cell_ctl;

    logic signed [COORD_W-1:0] w_x [MAX_POINTS];
    logic signed [COORD_W-1:0] w_y [MAX_POINTS];
    logic signed [COORD_W-1:0] nbr_x [MAX_POINTS];
    logic signed [COORD_W-1:0] nbr_y [MAX_POINTS];
    logic [MAX_POINTS-1:0]     wr_en;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign eval_start = in_accept && (in_item.kind == KIND_EVAL);

    // Clamp the configured count into the range the chain supports.
    always_comb
    begin
        priority if (point_count_reg == '0)
            count_eff = CNT_EFF_W'(1);
        else if (int'(point_count_reg) > MAX_POINTS)
            count_eff = CNT_EFF_W'(MAX_POINTS);
        else
            count_eff = CNT_EFF_W'(point_count_reg);
    end

    always_comb
    begin
        cell_ctl.copy = eval_start;
        cell_ctl.mul  = (state_reg == ST_MUL);
        cell_ctl.add  = (state_reg == ST_ADD);
    end

    // Chain of cells: each takes its right neighbor's working point; the last
    // cell sees its own, which only feeds entries past the end of the curve.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            assign wr_en[gi] = in_accept && (in_item.kind == KIND_LOAD)
                               && (int'(in_item.point_index) == gi);

            if (gi == MAX_POINTS - 1)
            begin : g_tail
                assign nbr_x[gi] = w_x[gi];
                assign nbr_y[gi] = w_y[gi];
            end
            else
            begin : g_link
                assign nbr_x[gi] = w_x[gi+1];
                assign nbr_y[gi] = w_y[gi+1];
            end

            bpe_cell u_cell (
                .clk   (clk),
                .ctl   (cell_ctl),
                .wr_en (wr_en[gi]),
                .wr_x  (in_item.point_x),
                .wr_y  (in_item.point_y),
                .t     (t_reg),
                .nbr_x (nbr_x[gi]),
                .nbr_y (nbr_y[gi]),
                .w_x   (w_x[gi]),
                .w_y   (w_y[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        rounds_next      = rounds_reg;
        t_next           = t_reg;
        out_valid_next   = out_valid_reg;
        out_item_next    = out_item_reg;
        point_count_next = cfg_wr_en ? cfg_wr_data : point_count_reg;

        // Drop the result once the receiver takes it.
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (eval_start)
                begin
                    t_next      = (in_item.t_value > T_ONE) ? T_ONE : in_item.t_value;
                    rounds_next = RND_W'(count_eff - CNT_EFF_W'(1));
                    state_next  = (count_eff == CNT_EFF_W'(1)) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (rounds_reg == RND_W'(1))
                    state_next = ST_OUT;
                else
                begin
                    rounds_next = rounds_reg - RND_W'(1);
                    state_next  = ST_MUL;
                end
            end
            ST_OUT:
            begin
                // Hold until the output slot is free, then hand over cell 0.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_item_next.curve_x = w_x[0];
                    out_item_next.curve_y = w_y[0];
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= COUNT_RESET;
            rounds_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            rounds_reg      <= rounds_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `include "assert_macros.svh"

    `BPE_ASSERT_NEXT(a_single_point, clk, rst_n, eval_start && count_eff == CNT_EFF_W'(1), state_reg == ST_OUT, "single point evaluate must go straight to output")
    `BPE_ASSERT_NEXT(a_last_round, clk, rst_n, state_reg == ST_ADD && rounds_reg == RND_W'(1), state_reg == ST_OUT, "last round must end in output state")
    `BPE_ASSERT(a_out_source, clk, rst_n, (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg == ST_OUT), "result appeared outside the output state")

endmodule

`default_nettype wire

/* rtl/bpe_cell.sv */
// One cell of the de Casteljau chain: a control point, a working point and products.
// Depends on bpe_pkg; instantiated MAX_POINTS times by bezier_point_evaluator.
`default_nettype none

module bpe_cell
    import bpe_pkg::*;
(
    input  wire                       clk,
    input  wire bpe_cell_ctl_t        ctl,
    input  wire                       wr_en,
    input  wire signed [COORD_W-1:0]  wr_x,
    input  wire signed [COORD_W-1:0]  wr_y,
    input  wire [T_W-1:0]             t,
    input  wire signed [COORD_W-1:0]  nbr_x,
    input  wire signed [COORD_W-1:0]  nbr_y,
    output logic signed [COORD_W-1:0] w_x,
    output logic signed [COORD_W-1:0] w_y
);

    logic signed [COORD_W-1:0] ctrl_x_reg, ctrl_x_next;
    logic signed [COORD_W-1:0] ctrl_y_reg, ctrl_y_next;
    logic signed [COORD_W-1:0] w_x_reg, w_x_next;
    logic signed [COORD_W-1:0] w_y_reg, w_y_next;
    logic signed [PROD_W-1:0]  prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_reg, prod_y_next;

    logic signed [COORD_W:0]   diff_x, diff_y;
    logic signed [T_W:0]       t_s;
    logic signed [PROD_W-1:0]  shift_x, shift_y;

    always_comb
    begin
        t_s    = $signed({1'b0, t});
        diff_x = $signed({nbr_x[COORD_W-1], nbr_x}) - $signed({w_x_reg[COORD_W-1], w_x_reg});
        diff_y = $signed({nbr_y[COORD_W-1], nbr_y}) - $signed({w_y_reg[COORD_W-1], w_y_reg});
        shift_x = prod_x_reg >>> T_FRAC_BITS;
        shift_y = prod_y_reg >>> T_FRAC_BITS;

        ctrl_x_next = wr_en ? wr_x : ctrl_x_reg;
        ctrl_y_next = wr_en ? wr_y : ctrl_y_reg;

        prod_x_next = ctl.mul ? PROD_W'(diff_x * t_s) : prod_x_reg;
        prod_y_next = ctl.mul ? PROD_W'(diff_y * t_s) : prod_y_reg;

        // The interpolant stays between its two ends, so COORD_W bits hold it.
        priority if (ctl.copy)
        begin
            w_x_next = ctrl_x_reg;
            w_y_next = ctrl_y_reg;
        end
        else if (ctl.add)
        begin
            w_x_next = w_x_reg + shift_x[COORD_W-1:0];
            w_y_next = w_y_reg + shift_y[COORD_W-1:0];
        end
        else
        begin
            w_x_next = w_x_reg;
            w_y_next = w_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_x_reg <= ctrl_x_next;
        ctrl_y_reg <= ctrl_y_next;
        w_x_reg    <= w_x_next;
        w_y_reg    <= w_y_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
    end

    assign w_x = w_x_reg;
    assign w_y = w_y_reg;

endmodule

`default_nettype wire
